>>> sv/tsdf_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the TSDF voxel integrator.
// No dependencies; tsdf_if and tsdf_voxel_integrator import this package.
package tsdf_pkg;

    // Default image and grid geometry
    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;
    localparam int GRID_DIM_DEF     = 512;

    // Configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_COL0,
        CFG_ROT_COL1,
        CFG_ROT_COL2,
        CFG_TRANSLATION,
        CFG_INTRINSICS,
        CFG_GRID_ORIGIN,
        CFG_VOXEL_SIZE,
        CFG_TRUNC_MARGIN
    } cfg_reg_e;

    localparam logic [47:0] ROT_COL0_RST     = 48'h0000_0000_4000;
    localparam logic [47:0] ROT_COL1_RST     = 48'h0000_4000_0000;
    localparam logic [47:0] ROT_COL2_RST     = 48'h4000_0000_0000;
    localparam logic [15:0] VOXEL_SIZE_RST   = 16'd393;
    localparam logic [15:0] TRUNC_MARGIN_RST = 16'd1966;

    // Item field widths
    localparam int PIX_IDX_W = 19;
    localparam int DEPTH_W   = 16;
    localparam int COORD_W   = 9;
    localparam int TSDF_W    = 16;
    localparam int WEIGHT_W  = 16;

    // Internal datapath widths
    localparam int TW       = 28;   // voxel minus camera, Q.16 m
    localparam int CAM_W    = 44;   // camera point, Q.30 m
    localparam int PROJ_W   = 64;   // projection and distance dividends
    localparam int DIFF_W   = 60;   // depth difference, 1e4 * 2^30 per m
    localparam int MARGIN_W = 44;
    localparam int AVG_W    = 36;   // running average dividend
    localparam int DIST_QW  = 15;
    localparam int AVG_QW   = 16;
    localparam int DIST_SHIFT = 15; // 2 * 16384 when forming the rounded dividend

    // Depth and scale constants
    localparam logic [DEPTH_W-1:0] DEPTH_MIN    = 16'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX    = 16'd60000;
    localparam logic [14:0]        DEPTH_PER_M  = 15'd10000;
    localparam logic [27:0]        MARGIN_SCALE = 28'd163840000; // 10000 * 16384
    localparam logic signed [TSDF_W-1:0] DIST_ONE = 16'sd16384;

    // Item traveling down the pipeline
    typedef struct packed {
        logic                       load;
        logic [PIX_IDX_W-1:0]       pix_idx;
        logic [DEPTH_W-1:0]         depth;
        logic signed [TSDF_W-1:0]   old_tsdf;
        logic [WEIGHT_W-1:0]        old_weight;
        logic                       skip;
    } item_t;

    // Sideband through the projection divider
    typedef struct packed {
        item_t                      item;
        logic signed [CAM_W-1:0]    cz;
        logic                       neg_x;
        logic                       ovf_x;
        logic                       ovf_y;
    } proj_side_t;

    // Sideband through the distance divider
    typedef struct packed {
        item_t item;
        logic  neg;
        logic  sat;
    } dist_side_t;

    // Sideband through the averaging divider
    typedef struct packed {
        item_t item;
        logic  neg;
    } avg_side_t;

    // Signed 16-bit field k of a packed register word
    function automatic logic signed [15:0] s16(input logic [63:0] word, input int unsigned k);
        return $signed(word[16*k +: 16]);
    endfunction

endpackage

>>> sv/tsdf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response items.
// Depends on tsdf_pkg for field widths.
interface tsdf_req_if
    import tsdf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [PIX_IDX_W-1:0]     pixel_index;
    logic [DEPTH_W-1:0]       depth_sample;
    logic [COORD_W-1:0]       voxel_x;
    logic [COORD_W-1:0]       voxel_y;
    logic [COORD_W-1:0]       voxel_z;
    logic signed [TSDF_W-1:0] old_tsdf;
    logic [WEIGHT_W-1:0]      old_weight;

    modport source (output valid, req_type, pixel_index, depth_sample, voxel_x, voxel_y,
                    voxel_z, old_tsdf, old_weight, input ready);
    modport sink   (input valid, req_type, pixel_index, depth_sample, voxel_x, voxel_y,
                    voxel_z, old_tsdf, old_weight, output ready);
endinterface

interface tsdf_rsp_if
    import tsdf_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     voxel_updated;
    logic signed [TSDF_W-1:0] new_tsdf;
    logic [WEIGHT_W-1:0]      new_weight;

    modport source (output valid, voxel_updated, new_tsdf, new_weight, input ready);
    modport sink   (input valid, voxel_updated, new_tsdf, new_weight, output ready);
endinterface

>>> sv/tsdf_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Standalone; the caller guarantees num < den << QW.
module tsdf_div #(
    parameter int W  = 64,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] out_side
);

    logic [W-1:0]  rem_in  [QW];
    logic [W-1:0]  den_in  [QW];
    logic [QW-1:0] quo_in  [QW];
    logic [SW-1:0] side_in [QW];
    logic [QW-1:0] vld_in;

    logic [W-1:0]  rem_reg  [QW-1];
    logic [W-1:0]  den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] vld_reg;

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [W-1:0] dsh;
        logic         take;

        // stage inputs
        if (i == 0) begin : g_first
            assign rem_in[i]  = num;
            assign den_in[i]  = den;
            assign quo_in[i]  = '0;
            assign side_in[i] = side;
            assign vld_in[i]  = in_valid;
        end else begin : g_next
            assign rem_in[i]  = rem_reg[i-1];
            assign den_in[i]  = den_reg[i-1];
            assign quo_in[i]  = quo_reg[i-1];
            assign side_in[i] = side_reg[i-1];
            assign vld_in[i]  = vld_reg[i-1];
        end

        // trial subtract for quotient bit QW-1-i
        assign dsh  = den_in[i] << (QW - 1 - i);
        assign take = rem_in[i] >= dsh;

        always_ff @(posedge clk) begin
            if (en) begin
                den_reg[i]  <= den_in[i];
                quo_reg[i]  <= quo_in[i] | (take ? (QW'(1) << (QW - 1 - i)) : '0);
                side_reg[i] <= side_in[i];
            end
        end

        if (i < QW - 1) begin : g_rem
            always_ff @(posedge clk) begin
                if (en) begin
                    rem_reg[i] <= take ? rem_in[i] - dsh : rem_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in[i];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

>>> sv/tsdf_voxel_integrator.sv
`timescale 1ns / 1ps
// TSDF voxel integrator: takes one item per clock while not stalled (depth pixel load or
// voxel update) and returns one result per voxel item, in order. The pipeline holds three
// bit-per-stage dividers (pixel projection, normalized distance, weighted average). Depth
// loads write the frame store at the same pipeline stage where voxels read it, so loads and
// voxels take effect in arrival order. The whole pipeline advances together and halts only
// while a result waits at the output; voxel_req.ready is high whenever the output register
// is empty or being taken.
// Depends on tsdf_pkg, tsdf_if and tsdf_div.
module tsdf_voxel_integrator
    import tsdf_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF,
    parameter int GRID_DIM     = GRID_DIM_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tsdf_req_if.sink             voxel_req,
    tsdf_rsp_if.source           voxel_rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int AW     = $clog2(PIXELS);
    localparam int QB     = $clog2(IMAGE_WIDTH > IMAGE_HEIGHT ? IMAGE_WIDTH : IMAGE_HEIGHT);
    localparam int CPW    = COORD_W + 16;

    // ---------------- configuration registers ----------------
    logic [47:0] rot_reg [3];
    logic [47:0] trans_reg;
    logic [63:0] intr_reg;
    logic [47:0] org_reg;
    logic [15:0] vsize_reg;
    logic [15:0] tmarg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rot_reg[0] <= ROT_COL0_RST;
            rot_reg[1] <= ROT_COL1_RST;
            rot_reg[2] <= ROT_COL2_RST;
            trans_reg  <= '0;
            intr_reg   <= '0;
            org_reg    <= '0;
            vsize_reg  <= VOXEL_SIZE_RST;
            tmarg_reg  <= TRUNC_MARGIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_ROT_COL0:     rot_reg[0] <= cfg_data[47:0];
                CFG_ROT_COL1:     rot_reg[1] <= cfg_data[47:0];
                CFG_ROT_COL2:     rot_reg[2] <= cfg_data[47:0];
                CFG_TRANSLATION:  trans_reg  <= cfg_data[47:0];
                CFG_INTRINSICS:   intr_reg   <= cfg_data;
                CFG_GRID_ORIGIN:  org_reg    <= cfg_data[47:0];
                CFG_VOXEL_SIZE:   vsize_reg  <= cfg_data[15:0];
                CFG_TRUNC_MARGIN: tmarg_reg  <= cfg_data[15:0];
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic en;
    assign en              = !voxel_rsp.valid || voxel_rsp.ready;
    assign voxel_req.ready = en;

    // ---------------- S1: voxel minus camera position ----------------
    item_t                s1_item_next, s1_item_reg;
    logic signed [TW-1:0] s1_t_next [3];
    logic signed [TW-1:0] s1_t_reg  [3];
    logic                 s1_vld_reg;
    logic [COORD_W-1:0]   coord [3];
    logic [CPW-1:0]       coord_len [3];

    always_comb begin
        coord[0] = voxel_req.voxel_x;
        coord[1] = voxel_req.voxel_y;
        coord[2] = voxel_req.voxel_z;
        s1_item_next.load       = !voxel_req.req_type;
        s1_item_next.pix_idx    = voxel_req.pixel_index;
        s1_item_next.depth      = voxel_req.depth_sample;
        s1_item_next.old_tsdf   = voxel_req.old_tsdf;
        s1_item_next.old_weight = voxel_req.old_weight;
        s1_item_next.skip       = 1'b0;
        for (int k = 0; k < 3; k++) begin
            coord_len[k] = CPW'(coord[k]) * CPW'(vsize_reg);
            s1_t_next[k] = (TW'(s16(64'(org_reg), k)) <<< 4)
                         + TW'($signed({1'b0, coord_len[k]}))
                         - (TW'(s16(64'(trans_reg), k)) <<< 4);
            if (32'(coord[k]) >= 32'(GRID_DIM)) begin
                s1_item_next.skip = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s1_item_reg <= s1_item_next;
            s1_t_reg    <= s1_t_next;
        end
    end

    // ---------------- S2: rotation products ----------------
    logic signed [CAM_W-1:0] s2_p_next [3][3];
    logic signed [CAM_W-1:0] s2_p_reg  [3][3];
    item_t                   s2_item_reg;
    logic                    s2_vld_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
                s2_p_next[c][k] = CAM_W'(s16(64'(rot_reg[c]), k)) * CAM_W'(s1_t_reg[k]);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s2_p_reg    <= s2_p_next;
            s2_item_reg <= s1_item_reg;
        end
    end

    // ---------------- S3: camera point ----------------
    logic signed [CAM_W-1:0] s3_cam_next [3];
    logic signed [CAM_W-1:0] s3_cam_reg  [3];
    item_t                   s3_item_reg;
    logic                    s3_vld_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s3_cam_next[c] = s2_p_reg[c][0] + s2_p_reg[c][1] + s2_p_reg[c][2];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s3_cam_reg  <= s3_cam_next;
            s3_item_reg <= s2_item_reg;
        end
    end

    // ---------------- S4: intrinsics products, depth test ----------------
    logic signed [PROJ_W-1:0] s4_fxcx_next, s4_cxcz_next, s4_fycy_next, s4_cycz_next;
    logic signed [PROJ_W-1:0] s4_fxcx_reg, s4_cxcz_reg, s4_fycy_reg, s4_cycz_reg;
    logic signed [CAM_W-1:0]  s4_cz_reg;
    item_t                    s4_item_next, s4_item_reg;
    logic                     s4_vld_reg;

    always_comb begin
        s4_fxcx_next = PROJ_W'($signed({1'b0, intr_reg[15:0]}))  * PROJ_W'(s3_cam_reg[0]);
        s4_fycy_next = PROJ_W'($signed({1'b0, intr_reg[31:16]})) * PROJ_W'(s3_cam_reg[1]);
        s4_cxcz_next = PROJ_W'($signed({1'b0, intr_reg[47:32]})) * PROJ_W'(s3_cam_reg[2]);
        s4_cycz_next = PROJ_W'($signed({1'b0, intr_reg[63:48]})) * PROJ_W'(s3_cam_reg[2]);
        s4_item_next = s3_item_reg;
        if (s3_cam_reg[2] <= 0) begin
            s4_item_next.skip = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s4_fxcx_reg <= s4_fxcx_next;
            s4_cxcz_reg <= s4_cxcz_next;
            s4_fycy_reg <= s4_fycy_next;
            s4_cycz_reg <= s4_cycz_next;
            s4_cz_reg   <= s3_cam_reg[2];
            s4_item_reg <= s4_item_next;
        end
    end

    // ---------------- S5: projection numerators ----------------
    logic signed [PROJ_W-1:0] s5_nx_reg, s5_ny_reg;
    logic signed [CAM_W-1:0]  s5_cz_reg;
    item_t                    s5_item_reg;
    logic                     s5_vld_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            s5_nx_reg   <= s4_fxcx_reg + s4_cxcz_reg;
            s5_ny_reg   <= s4_fycy_reg + s4_cycz_reg;
            s5_cz_reg   <= s4_cz_reg;
            s5_item_reg <= s4_item_reg;
        end
    end

    // ---------------- S6: rounded dividends, 2|n| + 16cz over 32cz ----------------
    logic [PROJ_W-1:0]       s6_nx_next, s6_ny_next, s6_den_next;
    logic [PROJ_W-1:0]       s6_nx_reg, s6_ny_reg, s6_den_reg;
    logic                    s6_negx_reg, s6_negy_reg;
    logic signed [CAM_W-1:0] s6_cz_reg;
    item_t                   s6_item_reg;
    logic                    s6_vld_reg;
    logic [PROJ_W-1:0]       absx, absy, cz16;

    always_comb begin
        absx        = s5_nx_reg < 0 ? PROJ_W'(-s5_nx_reg) : PROJ_W'(s5_nx_reg);
        absy        = s5_ny_reg < 0 ? PROJ_W'(-s5_ny_reg) : PROJ_W'(s5_ny_reg);
        cz16        = PROJ_W'(s5_cz_reg) << 4;
        s6_nx_next  = (absx << 1) + cz16;
        s6_ny_next  = (absy << 1) + cz16;
        s6_den_next = cz16 << 1;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s6_nx_reg   <= s6_nx_next;
            s6_ny_reg   <= s6_ny_next;
            s6_den_reg  <= s6_den_next;
            s6_negx_reg <= s5_nx_reg < 0;
            s6_negy_reg <= s5_ny_reg < 0;
            s6_cz_reg   <= s5_cz_reg;
            s6_item_reg <= s5_item_reg;
        end
    end

    // ---------------- S7: quotient overflow check ----------------
    logic [PROJ_W-1:0] s7_nx_reg, s7_ny_reg, s7_den_reg;
    proj_side_t        s7_side_next, s7_side_reg;
    logic              s7_negy_reg;
    logic              s7_vld_reg;

    always_comb begin
        s7_side_next.item  = s6_item_reg;
        s7_side_next.cz    = s6_cz_reg;
        s7_side_next.neg_x = s6_negx_reg;
        s7_side_next.ovf_x = s6_nx_reg >= (s6_den_reg << QB);
        s7_side_next.ovf_y = s6_ny_reg >= (s6_den_reg << QB);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s7_nx_reg   <= s6_nx_reg;
            s7_ny_reg   <= s6_ny_reg;
            s7_den_reg  <= s6_den_reg;
            s7_negy_reg <= s6_negy_reg;
            s7_side_reg <= s7_side_next;
        end
    end

    // ---------------- projection dividers ----------------
    logic             dx_vld, dy_vld;
    logic [QB-1:0]    qx, qy;
    proj_side_t       dx_side;
    logic             dy_negy;

    tsdf_div #(.W(PROJ_W), .QW(QB), .SW($bits(proj_side_t))) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_vld_reg),
        .num       (s7_nx_reg),
        .den       (s7_den_reg),
        .side      (s7_side_reg),
        .out_valid (dx_vld),
        .quo       (qx),
        .out_side  (dx_side)
    );

    tsdf_div #(.W(PROJ_W), .QW(QB), .SW(1)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_vld_reg),
        .num       (s7_ny_reg),
        .den       (s7_den_reg),
        .side      (s7_negy_reg),
        .out_valid (dy_vld),
        .quo       (qy),
        .out_side  (dy_negy)
    );

    // ---------------- S8: image bounds, frame store address ----------------
    item_t                   s8_item_next, s8_item_reg;
    logic [AW-1:0]           s8_addr_next, s8_addr_reg;
    logic                    s8_we_next, s8_we_reg;
    logic signed [CAM_W-1:0] s8_cz_reg;
    logic                    s8_vld_reg;
    logic                    on_image;
    logic [31:0]             addr_wide;

    always_comb begin
        on_image = !dx_side.ovf_x && !dx_side.ovf_y
                && (!dx_side.neg_x || qx == '0) && (!dy_negy || qy == '0)
                && (32'(qx) < 32'(IMAGE_WIDTH)) && (32'(qy) < 32'(IMAGE_HEIGHT));
        s8_item_next = dx_side.item;
        if (dx_side.item.load) begin
            addr_wide  = 32'(dx_side.item.pix_idx);
            s8_we_next = addr_wide < 32'(PIXELS);
        end else begin
            addr_wide  = 32'(qy) * 32'(IMAGE_WIDTH) + 32'(qx);
            s8_we_next = 1'b0;
            if (!on_image) begin
                s8_item_next.skip = 1'b1;
            end
        end
        s8_addr_next = addr_wide[AW-1:0];
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s8_item_reg <= s8_item_next;
            s8_addr_reg <= s8_addr_next;
            s8_we_reg   <= s8_we_next;
            s8_cz_reg   <= dx_side.cz;
        end
    end

    // ---------------- S9: frame store ----------------
    logic [DEPTH_W-1:0]      depth_mem [PIXELS];
    logic [DEPTH_W-1:0]      s9_d_reg;
    item_t                   s9_item_reg;
    logic signed [CAM_W-1:0] s9_cz_reg;
    logic                    s9_vld_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            if (s8_vld_reg && s8_we_reg) begin
                depth_mem[s8_addr_reg] <= s8_item_reg.depth;
            end
            s9_d_reg <= depth_mem[s8_addr_reg];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s9_item_reg <= s8_item_reg;
            s9_cz_reg   <= s8_cz_reg;
        end
    end

    // ---------------- S10: depth window, scaled terms ----------------
    item_t                     s10_item_next, s10_item_reg;
    logic signed [DIFF_W-1:0]  s10_czp_reg;
    logic [MARGIN_W-1:0]       s10_margin_reg;
    logic [DEPTH_W-1:0]        s10_d_reg;
    logic                      s10_vld_reg;

    always_comb begin
        s10_item_next = s9_item_reg;
        if (s9_d_reg <= DEPTH_MIN || s9_d_reg > DEPTH_MAX || tmarg_reg == '0) begin
            s10_item_next.skip = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s10_item_reg   <= s10_item_next;
            s10_czp_reg    <= DIFF_W'(s9_cz_reg) * DIFF_W'($signed({1'b0, DEPTH_PER_M}));
            s10_margin_reg <= MARGIN_W'(tmarg_reg) * MARGIN_W'(MARGIN_SCALE);
            s10_d_reg      <= s9_d_reg;
        end
    end

    // ---------------- S11: depth difference ----------------
    logic signed [DIFF_W-1:0] s11_diff_reg;
    logic [MARGIN_W-1:0]      s11_margin_reg;
    item_t                    s11_item_reg;
    logic                     s11_vld_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            s11_diff_reg   <= $signed(DIFF_W'(s10_d_reg) << 30) - s10_czp_reg;
            s11_margin_reg <= s10_margin_reg;
            s11_item_reg   <= s10_item_reg;
        end
    end

    // ---------------- S12: truncation tests ----------------
    item_t                 s12_item_next, s12_item_reg;
    logic [DIFF_W-1:0]     s12_absd_reg;
    logic [MARGIN_W-1:0]   s12_margin_reg;
    logic                  s12_neg_reg, s12_sat_reg;
    logic                  s12_vld_reg;
    logic signed [DIFF_W:0] lo_sum;
    logic signed [DIFF_W-1:0] margin_s;

    always_comb begin
        margin_s      = $signed(DIFF_W'(s11_margin_reg));
        lo_sum        = (DIFF_W+1)'(s11_diff_reg) + (DIFF_W+1)'(margin_s);
        s12_item_next = s11_item_reg;
        if (lo_sum <= 0) begin
            s12_item_next.skip = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s12_item_reg   <= s12_item_next;
            s12_absd_reg   <= s11_diff_reg < 0 ? DIFF_W'(-s11_diff_reg) : DIFF_W'(s11_diff_reg);
            s12_neg_reg    <= s11_diff_reg < 0;
            s12_sat_reg    <= s11_diff_reg >= margin_s;
            s12_margin_reg <= s11_margin_reg;
        end
    end

    // ---------------- S13: distance dividend ----------------
    logic [PROJ_W-1:0] s13_num_reg, s13_den_reg;
    dist_side_t        s13_side_reg;
    logic              s13_vld_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            s13_num_reg        <= (PROJ_W'(s12_absd_reg) << DIST_SHIFT) + PROJ_W'(s12_margin_reg);
            s13_den_reg        <= PROJ_W'(s12_margin_reg) << 1;
            s13_side_reg.item  <= s12_item_reg;
            s13_side_reg.neg   <= s12_neg_reg;
            s13_side_reg.sat   <= s12_sat_reg;
        end
    end

    logic               dd_vld;
    logic [DIST_QW-1:0] qd;
    dist_side_t         dd_side;

    tsdf_div #(.W(PROJ_W), .QW(DIST_QW), .SW($bits(dist_side_t))) u_div_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s13_vld_reg),
        .num       (s13_num_reg),
        .den       (s13_den_reg),
        .side      (s13_side_reg),
        .out_valid (dd_vld),
        .quo       (qd),
        .out_side  (dd_side)
    );

    // ---------------- S14: normalized distance, old sum ----------------
    logic signed [TSDF_W-1:0] s14_dist_next, s14_dist_reg;
    logic signed [AVG_W-1:0]  s14_prod_reg;
    item_t                    s14_item_reg;
    logic                     s14_vld_reg;

    always_comb begin
        if (dd_side.sat) begin
            s14_dist_next = DIST_ONE;
        end else if (dd_side.neg) begin
            s14_dist_next = TSDF_W'(-$signed({1'b0, qd}));
        end else begin
            s14_dist_next = TSDF_W'($signed({1'b0, qd}));
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s14_dist_reg <= s14_dist_next;
            s14_prod_reg <= AVG_W'(dd_side.item.old_tsdf)
                          * AVG_W'($signed({1'b0, dd_side.item.old_weight}));
            s14_item_reg <= dd_side.item;
        end
    end

    // ---------------- S15: new sum and count ----------------
    logic signed [AVG_W-1:0] s15_n_reg;
    logic [WEIGHT_W:0]       s15_den_reg;
    item_t                   s15_item_reg;
    logic                    s15_vld_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            s15_n_reg    <= s14_prod_reg + AVG_W'(s14_dist_reg);
            s15_den_reg  <= (WEIGHT_W+1)'(s14_item_reg.old_weight) + 1'b1;
            s15_item_reg <= s14_item_reg;
        end
    end

    // ---------------- S16: average dividend ----------------
    logic [AVG_W-1:0] s16_num_reg, s16_den_reg;
    logic [AVG_W-1:0] absn;
    avg_side_t        s16_side_reg;
    logic             s16_vld_reg;

    assign absn = s15_n_reg < 0 ? AVG_W'(-s15_n_reg) : AVG_W'(s15_n_reg);

    always_ff @(posedge clk) begin
        if (en) begin
            s16_num_reg       <= (absn << 1) + AVG_W'(s15_den_reg);
            s16_den_reg       <= AVG_W'(s15_den_reg) << 1;
            s16_side_reg.item <= s15_item_reg;
            s16_side_reg.neg  <= s15_n_reg < 0;
        end
    end

    logic              da_vld;
    logic [AVG_QW-1:0] qa;
    avg_side_t         da_side;

    tsdf_div #(.W(AVG_W), .QW(AVG_QW), .SW($bits(avg_side_t))) u_div_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s16_vld_reg),
        .num       (s16_num_reg),
        .den       (s16_den_reg),
        .side      (s16_side_reg),
        .out_valid (da_vld),
        .quo       (qa),
        .out_side  (da_side)
    );

    // ---------------- S17: output register ----------------
    logic                     s17_vld_reg;
    logic                     s17_load_reg;
    logic                     s17_upd_reg;
    logic signed [TSDF_W-1:0] s17_tsdf_next, s17_tsdf_reg;
    logic [WEIGHT_W-1:0]      s17_weight_next, s17_weight_reg;

    always_comb begin
        if (da_side.item.skip) begin
            s17_tsdf_next   = da_side.item.old_tsdf;
            s17_weight_next = da_side.item.old_weight;
        end else begin
            s17_tsdf_next   = da_side.neg ? $signed(TSDF_W'(-qa)) : $signed(TSDF_W'(qa));
            s17_weight_next = (&da_side.item.old_weight) ? da_side.item.old_weight
                                                         : da_side.item.old_weight + 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s17_load_reg   <= da_side.item.load;
            s17_upd_reg    <= !da_side.item.skip;
            s17_tsdf_reg   <= s17_tsdf_next;
            s17_weight_reg <= s17_weight_next;
        end
    end

    assign voxel_rsp.valid         = s17_vld_reg && !s17_load_reg;
    assign voxel_rsp.voxel_updated = s17_upd_reg;
    assign voxel_rsp.new_tsdf      = s17_tsdf_reg;
    assign voxel_rsp.new_weight    = s17_weight_reg;

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            s12_vld_reg <= 1'b0;
            s13_vld_reg <= 1'b0;
            s14_vld_reg <= 1'b0;
            s15_vld_reg <= 1'b0;
            s16_vld_reg <= 1'b0;
            s17_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= voxel_req.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= dx_vld;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
            s12_vld_reg <= s11_vld_reg;
            s13_vld_reg <= s12_vld_reg;
            s14_vld_reg <= dd_vld;
            s15_vld_reg <= s14_vld_reg;
            s16_vld_reg <= s15_vld_reg;
            s17_vld_reg <= da_vld;
        end
    end

`ifndef SYNTH
    // x and y projection dividers run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dx_vld == dy_vld)
        else $error("projection dividers out of step");

    // an integrated voxel always carries a nonzero weight
    a_upd_weight: assert property (@(posedge clk) disable iff (!rst_n)
        voxel_rsp.valid && voxel_rsp.voxel_updated |-> voxel_rsp.new_weight != '0)
        else $error("integrated voxel with zero weight");

    // a stall freezes the first stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s1_vld_reg) && $stable(s1_item_reg))
        else $error("pipeline moved during stall");
`endif

endmodule
